[src/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes and the configuration bundle for the
// clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int MEAS_W = 16;
	localparam int GAIN_W = 16;
	localparam int LIM_W  = 15;
	localparam int SUM_W  = 16;
	localparam int ERR_W  = MEAS_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = GAIN_W + ERR_W;
	localparam int PI_W   = GAIN_W + SUM_W;
	localparam int PD_W   = GAIN_W + DIFF_W;
	localparam int ACC_W  = PD_W + 2;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SETPOINT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRIVE_MIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_MAX = 3'd5;
	localparam logic [IDX_W-1:0] REG_INT_LIMIT = 3'd6;

	localparam logic [LIM_W-1:0] INT_LIMIT_RESET = 15'd2500;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic signed [MEAS_W-1:0] setpoint;
		logic signed [MEAS_W-1:0] drive_min;
		logic signed [MEAS_W-1:0] drive_max;
		logic [LIM_W-1:0]         integral_limit;
	} cfg_t;

endpackage

[src/pidc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Configuration register file, written one register per cycle.
// ----------------------------------------------------------------------------
module pidc_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	output pidc_pkg::cfg_t          cfg
);
	import pidc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.setpoint       <= '0;
			cfg_q.drive_min      <= '0;
			cfg_q.drive_max      <= '0;
			cfg_q.integral_limit <= INT_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    cfg_q.gain_p         <= cfg_data;
				REG_GAIN_I:    cfg_q.gain_i         <= cfg_data;
				REG_GAIN_D:    cfg_q.gain_d         <= cfg_data;
				REG_SETPOINT:  cfg_q.setpoint       <= cfg_data;
				REG_DRIVE_MIN: cfg_q.drive_min      <= cfg_data;
				REG_DRIVE_MAX: cfg_q.drive_max      <= cfg_data;
				REG_INT_LIMIT: cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/pidc_err_stage.sv]
// ----------------------------------------------------------------------------
// pidc_err_stage
// Error, clamped integral and difference; holds the controller state.
// ----------------------------------------------------------------------------
module pidc_err_stage (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    advance,
	input  logic                                    valid_s1,
	input  logic signed [pidc_pkg::MEAS_W-1:0]      meas_s1,
	input  logic signed [pidc_pkg::MEAS_W-1:0]      setpoint,
	input  logic [pidc_pkg::LIM_W-1:0]              integral_limit,
	output logic signed [pidc_pkg::ERR_W-1:0]       err,
	output logic signed [pidc_pkg::SUM_W-1:0]       err_sum,
	output logic signed [pidc_pkg::DIFF_W-1:0]      diff
);
	import pidc_pkg::*;

	localparam int WIDE_W = ERR_W + 1;

	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [WIDE_W-1:0] sum_raw;
	logic signed [WIDE_W-1:0] lim_pos;
	logic signed [WIDE_W-1:0] lim_neg;
	logic signed [WIDE_W-1:0] sum_clamped;

	always_comb begin
		err     = ERR_W'(setpoint) - ERR_W'(meas_s1);
		sum_raw = WIDE_W'(error_sum_q) + WIDE_W'(err);
		lim_pos = $signed({3'b000, integral_limit});
		lim_neg = -lim_pos;
		sum_clamped = sum_raw;
		if (sum_clamped > lim_pos)
			sum_clamped = lim_pos;
		if (sum_clamped < lim_neg)
			sum_clamped = lim_neg;
		err_sum = sum_clamped[SUM_W-1:0];
		diff    = DIFF_W'(err) - DIFF_W'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (advance && valid_s1) begin
			error_sum_q <= err_sum;
			prev_err_q  <= err;
		end
	end

endmodule

[src/pidc_mul_stage.sv]
// ----------------------------------------------------------------------------
// pidc_mul_stage
// Three parallel gain multiplies.
// ----------------------------------------------------------------------------
module pidc_mul_stage (
	input  logic signed [pidc_pkg::ERR_W-1:0]       err,
	input  logic signed [pidc_pkg::SUM_W-1:0]       err_sum,
	input  logic signed [pidc_pkg::DIFF_W-1:0]      diff,
	input  pidc_pkg::cfg_t                          cfg,
	output logic signed [pidc_pkg::PP_W-1:0]        prod_p,
	output logic signed [pidc_pkg::PI_W-1:0]        prod_i,
	output logic signed [pidc_pkg::PD_W-1:0]        prod_d
);
	import pidc_pkg::*;

	always_comb begin
		prod_p = PP_W'(cfg.gain_p) * PP_W'(err);
		prod_i = PI_W'(cfg.gain_i) * PI_W'(err_sum);
		prod_d = PD_W'(cfg.gain_d) * PD_W'(diff);
	end

endmodule

[src/pidc_clamp_stage.sv]
// ----------------------------------------------------------------------------
// pidc_clamp_stage
// Product sum, fractional shift and output clamp into the result register.
// ----------------------------------------------------------------------------
module pidc_clamp_stage #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    advance,
	input  logic                                    valid_s1,
	input  logic signed [pidc_pkg::PP_W-1:0]        prod_p,
	input  logic signed [pidc_pkg::PI_W-1:0]        prod_i,
	input  logic signed [pidc_pkg::PD_W-1:0]        prod_d,
	input  logic signed [pidc_pkg::MEAS_W-1:0]      drive_min,
	input  logic signed [pidc_pkg::MEAS_W-1:0]      drive_max,
	output logic                                    out_valid_q,
	output logic signed [pidc_pkg::MEAS_W-1:0]      drive_q
);
	import pidc_pkg::*;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] shifted;
	logic signed [ACC_W-1:0] clamped;

	always_comb begin
		acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
		shifted = acc >>> FRAC_BITS;
		clamped = shifted;
		if (clamped > ACC_W'(drive_max))
			clamped = ACC_W'(drive_max);
		if (clamped < ACC_W'(drive_min))
			clamped = ACC_W'(drive_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			drive_q <= clamped[MEAS_W-1:0];
	end

endmodule

[src/pid_controller_clamped.sv]
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Discrete PID controller with clamped integral and clamped output.
// ----------------------------------------------------------------------------
// Takes one measurement word per cycle while in_stall is low and returns one
// drive word per measurement, registered first in the input register and then
// in the result register. These two registers bracket the whole step (error,
// clamped integral, three gain multiplies, product sum, shift and output
// clamp); both move together and stall only while the output word is held.
// The integral and previous error update as a word moves into the result
// register, so back-to-back words see each other. The user must write
// configuration only while no word is in flight; the block does not check it.
module pid_controller_clamped #(
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  measurement,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  drive
);
	import pidc_pkg::*;

	cfg_t                      cfg;
	logic                      advance;
	logic                      valid_s1;
	logic signed [MEAS_W-1:0]  meas_s1;
	logic signed [ERR_W-1:0]   err;
	logic signed [SUM_W-1:0]   err_sum;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PP_W-1:0]    prod_p;
	logic signed [PI_W-1:0]    prod_i;
	logic signed [PD_W-1:0]    prod_d;
	logic                      out_valid_q;
	logic signed [MEAS_W-1:0]  drive_q;

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance)
			meas_s1 <= measurement;
	end

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidc_err_stage u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.meas_s1        (meas_s1),
		.setpoint       (cfg.setpoint),
		.integral_limit (cfg.integral_limit),
		.err            (err),
		.err_sum        (err_sum),
		.diff           (diff)
	);

	pidc_mul_stage u_mul (
		.err     (err),
		.err_sum (err_sum),
		.diff    (diff),
		.cfg     (cfg),
		.prod_p  (prod_p),
		.prod_i  (prod_i),
		.prod_d  (prod_d)
	);

	pidc_clamp_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_clamp (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.prod_p      (prod_p),
		.prod_i      (prod_i),
		.prod_d      (prod_d),
		.drive_min   (cfg.drive_min),
		.drive_max   (cfg.drive_max),
		.out_valid_q (out_valid_q),
		.drive_q     (drive_q)
	);

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule
